// File: hw/rtl/pbld_pkg.sv
// types and constants shared by the packbits line decoder
// no dependencies; compiled first
`default_nettype none

package pbld_pkg;

  localparam logic [7:0] SKIP_HEADER = 8'h80;
  localparam logic [15:0] LINE_WIDTH_RESET = 16'd1;
  localparam int unsigned LANES = 4;

  // register index decoded from paddr[2]
  localparam logic REG_LINE_WIDTH = 1'b0;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // one output word cut from the pending run
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic [7:0]  rest;
    logic        done;
  } chunk_t;

endpackage

`default_nettype wire

// File: hw/rtl/pbld_in_if.sv
// input channel of the packbits line decoder: one compressed byte per transfer
// no dependencies
`default_nettype none

interface pbld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       line_last;

  modport source (output valid, output code_byte, output line_last, input ready);
  modport sink (input valid, input code_byte, input line_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pbld_out_if.sv
// output channel of the packbits line decoder: up to four decoded bytes per transfer
// no dependencies
`default_nettype none

interface pbld_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_bytes;
  logic [2:0]  byte_count;
  logic        run_last;
  logic        line_end;

  modport source (output valid, output out_bytes, output byte_count, output run_last,
                  output line_end, input ready);
  modport sink (input valid, input out_bytes, input byte_count, input run_last,
                input line_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pbld_chunker.sv
// cuts the next word of up to four copies of a byte from a pending run length
// depends on pbld_pkg
`default_nettype none

module pbld_chunker (
  input  wire logic [7:0]      left,
  input  wire logic [7:0]      value,
  output pbld_pkg::chunk_t     chunk
);

  logic [2:0] count;

  always_comb begin
    count = (left >= 8'd4) ? 3'(pbld_pkg::LANES) : left[2:0];
    for (int i = 0; i < pbld_pkg::LANES; i++) begin
      chunk.word[8*i +: 8] = (3'(i) < count) ? value : 8'h00;
    end
    chunk.count = count;
    chunk.rest  = left - {5'b0, count};
    chunk.done  = (chunk.rest == 8'd0);
  end

endmodule

`default_nettype wire

// File: hw/rtl/packbits_line_decoder.sv
// packbits scan line decoder, top level
// depends on pbld_pkg, pbld_in_if, pbld_out_if, pbld_chunker
//
// in_ch carries one compressed byte per transfer with a line_last flag; out_ch
// carries results of up to four decoded bytes (first byte in bits 7:0).
// A literal byte gives one result of one byte; a repeat value byte gives
// ceil(n/4) results of four bytes but the last may be shorter. A line_last byte that
// decodes nothing gives one end marker with byte_count 0. run_last marks the
// final result of an input byte, line_end the final result of a line.
// An input byte is taken first, then the shared chunk unit cuts its results
// one after another. in_ch.ready is low while results of the current byte are
// still being produced.
// A held output register lets the next byte be taken while the last result
// still waits; when out_ch stalls the chunk unit waits with it.
// line_width is set over the APB port at address 0 (reset value 1); writing
// it restarts the line, as does a line_last byte. rst is synchronous and
// returns the block to the start of a line with line_width 1.
`default_nettype none

module packbits_line_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  pbld_in_if.sink          in_ch,
  pbld_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  pbld_pkg::state_t state;
  pbld_pkg::phase_t phase, phase_next;
  logic [15:0] line_width;
  logic [15:0] width_left, width_left_next;
  logic [7:0]  literal_left, literal_left_next;
  logic [7:0]  repeat_len, repeat_len_next;

  logic [7:0]  emit_left;
  logic [7:0]  emit_byte;
  logic        emit_end;
  logic [7:0]  emit_len;
  logic        produce;
  logic [7:0]  hdr_cnt;
  logic [7:0]  clamped;

  logic        out_valid;
  logic [31:0] out_bytes;
  logic [2:0]  byte_count;
  logic        run_last;
  logic        line_end;

  logic        accept;
  logic        cfg_write;
  logic        slot_free;
  pbld_pkg::chunk_t chunk;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == pbld_pkg::REG_LINE_WIDTH);
  assign prdata    = (paddr[2] == pbld_pkg::REG_LINE_WIDTH) ? {16'b0, line_width} : 32'b0;

  assign in_ch.ready = (state == pbld_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid || out_ch.ready;

  assign out_ch.valid      = out_valid;
  assign out_ch.out_bytes  = out_bytes;
  assign out_ch.byte_count = byte_count;
  assign out_ch.run_last   = run_last;
  assign out_ch.line_end   = line_end;

  pbld_chunker u_chunker (
    .left  (emit_left),
    .value (emit_byte),
    .chunk (chunk)
  );

  // header run length: 257 - b for repeats, b + 1 for literals
  always_comb begin
    if (in_ch.code_byte[7]) begin
      hdr_cnt = 8'(8'd0 - in_ch.code_byte) + 8'd1;
    end else begin
      hdr_cnt = in_ch.code_byte + 8'd1;
    end
    clamped = (width_left < {8'b0, hdr_cnt}) ? width_left[7:0] : hdr_cnt;
  end

  always_comb begin
    phase_next        = phase;
    width_left_next   = width_left;
    literal_left_next = literal_left;
    repeat_len_next   = repeat_len;
    emit_len          = 8'd0;
    produce           = 1'b0;
    unique case (phase)
      pbld_pkg::PH_LITERAL: begin
        emit_len          = 8'd1;
        produce           = 1'b1;
        literal_left_next = literal_left - 8'd1;
        if (literal_left_next == 8'd0) begin
          phase_next = pbld_pkg::PH_HEADER;
        end
      end
      pbld_pkg::PH_REPEAT: begin
        emit_len        = repeat_len;
        produce         = (repeat_len != 8'd0);
        width_left_next = width_left - {8'b0, repeat_len};
        repeat_len_next = 8'd0;
        phase_next      = pbld_pkg::PH_HEADER;
      end
      pbld_pkg::PH_HEADER: begin
        if (in_ch.code_byte == pbld_pkg::SKIP_HEADER) begin
          phase_next = pbld_pkg::PH_HEADER;
        end else if (in_ch.code_byte[7]) begin
          repeat_len_next = clamped;
          phase_next      = pbld_pkg::PH_REPEAT;
        end else begin
          width_left_next   = width_left - {8'b0, clamped};
          literal_left_next = clamped;
          phase_next        = (clamped != 8'd0) ? pbld_pkg::PH_LITERAL
                                                : pbld_pkg::PH_HEADER;
        end
      end
      default: begin
        phase_next = pbld_pkg::PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pbld_pkg::ST_IDLE;
      phase        <= pbld_pkg::PH_HEADER;
      line_width   <= pbld_pkg::LINE_WIDTH_RESET;
      width_left   <= pbld_pkg::LINE_WIDTH_RESET;
      literal_left <= 8'd0;
      repeat_len   <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        line_width   <= pwdata[15:0];
        width_left   <= pwdata[15:0];
        phase        <= pbld_pkg::PH_HEADER;
        literal_left <= 8'd0;
        repeat_len   <= 8'd0;
      end else if (accept) begin
        if (in_ch.line_last) begin
          // line ends: start over whatever run was open
          width_left   <= line_width;
          phase        <= pbld_pkg::PH_HEADER;
          literal_left <= 8'd0;
          repeat_len   <= 8'd0;
        end else begin
          width_left   <= width_left_next;
          phase        <= phase_next;
          literal_left <= literal_left_next;
          repeat_len   <= repeat_len_next;
        end
        if (produce || in_ch.line_last) begin
          state <= pbld_pkg::ST_EMIT;
        end
      end

      if (state == pbld_pkg::ST_EMIT && slot_free) begin
        out_valid <= 1'b1;
        if (chunk.done) begin
          state <= pbld_pkg::ST_IDLE;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      emit_left <= produce ? emit_len : 8'd0;
      emit_byte <= in_ch.code_byte;
      emit_end  <= in_ch.line_last;
    end else if (state == pbld_pkg::ST_EMIT && slot_free) begin
      emit_left <= chunk.rest;
    end
    if (state == pbld_pkg::ST_EMIT && slot_free) begin
      out_bytes  <= chunk.word;
      byte_count <= chunk.count;
      run_last   <= chunk.done;
      line_end   <= chunk.done && emit_end;
    end
  end

  // an end marker is always the final result of its line
  a_marker_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_count == 3'd0) |-> run_last && line_end)
    else $error("end marker without run_last and line_end");

  // only the final result of a byte may carry fewer than four bytes
  a_short_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_count != 3'd4) |-> run_last)
    else $error("short result before the end of a run");

  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end |-> run_last)
    else $error("line_end without run_last");

  a_literal_count: assert property (@(posedge clk) disable iff (rst)
    (phase == pbld_pkg::PH_LITERAL) |-> (literal_left != 8'd0))
    else $error("literal phase with no bytes left");

  // no new byte is taken while results of the previous one are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    accept && (produce || in_ch.line_last) |=> !in_ch.ready)
    else $error("input taken while results pending");

endmodule

`default_nettype wire

// File: verif/pbld_track_pkg.sv
// expected-word tracker for the packbits line decoder test: decodes each accepted
// code byte into the words the block must send, then checks the words it does send
// depends on pbld_pkg
`timescale 1ns / 1ps

package pbld_track_pkg;

  import pbld_pkg::*;

  class decoded_line_tracker;

    typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  count;
      logic        run_last;
      logic        line_end;
    } dec_word_t;

    dec_word_t expected_words[$];

    logic [15:0] line_width;
    phase_t      phase;
    logic [7:0]  literal_left;
    logic [7:0]  repeat_len;
    logic [15:0] width_left;

    int mismatches;
    int code_bytes;
    int lines;
    int words_checked;
    int width_writes;

    function new();
      line_width = LINE_WIDTH_RESET;
      restart_line();
    endfunction

    function void restart_line();
      phase = PH_HEADER;
      literal_left = 8'd0;
      repeat_len = 8'd0;
      width_left = line_width;
    endfunction

    function void set_line_width(logic [15:0] w);
      line_width = w;
      width_writes++;
      restart_line();
    endfunction

    function dec_word_t make_word(logic [31:0] bytes, logic [2:0] count);
      dec_word_t w;
      w.bytes = bytes;
      w.count = count;
      w.run_last = 1'b0;
      w.line_end = 1'b0;
      return w;
    endfunction

    function void decode_code_byte(logic [7:0] b, logic last);
      dec_word_t burst [0:32];
      int n;
      int cnt;
      int left;
      int c;
      logic [31:0] fill;
      n = 0;
      code_bytes++;
      case (phase)
        PH_LITERAL: begin
          burst[0] = make_word({24'd0, b}, 3'd1);
          n = 1;
          literal_left = literal_left - 8'd1;
          if (literal_left == 8'd0) phase = PH_HEADER;
        end
        PH_REPEAT: begin
          left = int'(repeat_len);
          fill = {4{b}};
          width_left = 16'(width_left - left);
          while (left > 0) begin
            c = (left > 4) ? 4 : left;
            burst[n] = make_word((c == 4) ? fill : fill & ((32'd1 << (8 * c)) - 32'd1),
                                 3'(c));
            n++;
            left = left - c;
          end
          repeat_len = 8'd0;
          phase = PH_HEADER;
        end
        default: begin
          if (b == SKIP_HEADER) begin
            // skip header, stays in header phase
          end else if (b > SKIP_HEADER) begin
            cnt = 257 - int'(b);
            if (cnt > width_left) cnt = int'(width_left);
            repeat_len = 8'(cnt);
            phase = PH_REPEAT;
          end else begin
            cnt = int'(b) + 1;
            if (cnt > width_left) cnt = int'(width_left);
            width_left = 16'(width_left - cnt);
            literal_left = 8'(cnt);
            phase = (cnt > 0) ? PH_LITERAL : PH_HEADER;
          end
        end
      endcase
      // line end with nothing decoded still sends an empty marker word
      if (last && n == 0) begin
        burst[0] = make_word(32'd0, 3'd0);
        n = 1;
      end
      if (n > 0) begin
        burst[n-1].run_last = 1'b1;
        burst[n-1].line_end = last;
      end
      for (int k = 0; k < n; k++) expected_words.push_back(burst[k]);
      if (last) begin
        lines++;
        restart_line();
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < 20) $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_word(logic [31:0] bytes, logic [2:0] count, logic run_last, logic line_end);
      dec_word_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with none expected: bytes %h count %0d",
                                  words_checked, bytes, count));
        return;
      end
      want = expected_words.pop_front();
      if (bytes !== want.bytes)
        report_mismatch($sformatf("word %0d out_bytes %h, want %h",
                                  words_checked, bytes, want.bytes));
      if (count !== want.count)
        report_mismatch($sformatf("word %0d byte_count %0d, want %0d",
                                  words_checked, count, want.count));
      if (run_last !== want.run_last)
        report_mismatch($sformatf("word %0d run_last %b, want %b",
                                  words_checked, run_last, want.run_last));
      if (line_end !== want.line_end)
        report_mismatch($sformatf("word %0d line_end %b, want %b",
                                  words_checked, line_end, want.line_end));
    endtask

    task finish_check();
      if (expected_words.size() != 0)
        report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));
    endtask

  endclass

endpackage

// File: verif/packbits_line_decoder_test.sv
// self-checking test of packbits_line_decoder: directed corner runs, then random
// scan lines with random gaps, stalls and line width changes over apb
// depends on pbld_pkg, pbld_track_pkg, pbld_in_if, pbld_out_if and the block
`timescale 1ns / 1ps

module packbits_line_decoder_test;

  import pbld_pkg::*;
  import pbld_track_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RANDOM_ITEMS = 270;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [2:0] WIDTH_ADDR = {REG_LINE_WIDTH, 2'b00};
  localparam logic [2:0] SPARE_ADDR = {~REG_LINE_WIDTH, 2'b00};

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pbld_in_if  in_ch ();
  pbld_out_if out_ch ();

  decoded_line_tracker board = new();

  bit         no_idle;
  int         stall_left;
  int         quiet_cycles;
  int         directed_bytes;
  logic [7:0] line_bytes[$];

  packbits_line_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // mostly no wait, some short ones, a few long
  function automatic int pick_wait();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_width();
    logic [31:0] r32;
    logic [15:0] w;
    int sel;
    r32 = $urandom();
    sel = $urandom_range(0, 9);
    if (sel == 0) w = 16'd0;
    else if (sel == 1) w = 16'hFFFF;
    else if (sel == 2) w = 16'd1;
    else if (sel < 7) w = 16'($urandom_range(2, 40));
    else w = 16'($urandom_range(41, 65534));
    return {r32[31:16], w};
  endfunction

  // result side: check every transfer, stall at random
  always @(posedge clk) begin : sink_side
    int hold;
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_word(out_ch.out_bytes, out_ch.byte_count, out_ch.run_last, out_ch.line_end);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      hold = pick_wait();
      out_ch.ready <= (hold == 0);
      stall_left <= (hold > 0) ? hold - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("packbits_line_decoder_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.code_byte <= b;
    in_ch.line_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    board.decode_code_byte(b, last);
  endtask

  // hold the sender until every expected word is out and the block has settled
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic [2:0] addr, input logic [31:0] data,
                            input logic write, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rdata = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_width_readback();
    logic [31:0] rd;
    apb_access(WIDTH_ADDR, 32'd0, 1'b0, rd);
    if (rd[15:0] !== board.line_width)
      board.report_mismatch($sformatf("line_width reads %h, want %h", rd[15:0], board.line_width));
  endtask

  task automatic write_line_width(input logic [31:0] data);
    logic [31:0] rd;
    apb_access(WIDTH_ADDR, data, 1'b1, rd);
    board.set_line_width(data[15:0]);
    check_width_readback();
  endtask

  // well-formed runs with random content, some lines cut short, some pure noise
  task automatic send_random_line();
    int kind;
    int runs;
    int r;
    int len;
    int cut;
    kind = $urandom_range(0, 9);
    line_bytes.delete();
    if (kind == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      runs = $urandom_range(1, 5);
      repeat (runs) begin
        r = $urandom_range(0, 19);
        if (r < 9) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 127) : $urandom_range(0, 7);
          line_bytes.push_back(8'(len));
          repeat (len + 1) line_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (r < 18) begin
          line_bytes.push_back(8'($urandom_range(8'h81, 8'hFF)));
          line_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          line_bytes.push_back(SKIP_HEADER);
        end
      end
      if (kind == 1) begin
        cut = $urandom_range(1, line_bytes.size());
        while (line_bytes.size() > cut) void'(line_bytes.pop_back());
      end
    end
    for (int k = 0; k < line_bytes.size(); k++)
      send_byte(line_bytes[k], k == line_bytes.size() - 1);
  endtask

  initial begin
    logic [31:0] rd;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.code_byte <= 8'd0;
    in_ch.line_last <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'd0;
    pwdata <= 32'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // unknown register index must leave the reset width alone
    apb_access(SPARE_ADDR, 32'h0000_0005, 1'b1, rd);
    check_width_readback();

    // width 1: one-byte literal fills the line, later runs clamp to nothing
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(SKIP_HEADER, 1'b1);

    wait_drained();
    write_line_width(32'hFFFF_FFFF);
    // longest repeat, then a literal and a repeat cut off by the line end
    send_byte(8'h81, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFE, 1'b1);

    wait_drained();
    write_line_width(32'h0000_0003);
    // literal of 5 clamped to 3, the surplus byte becomes a header
    send_byte(8'h04, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h80, 1'b1);

    wait_drained();
    write_line_width(32'hFFFF_0000);
    // zero width clamps every run
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'h77, 1'b1);
    directed_bytes = board.code_bytes;

    while (board.code_bytes < directed_bytes + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        if ($urandom_range(0, 5) == 0) apb_access(SPARE_ADDR, $urandom(), 1'b1, rd);
        write_line_width(pick_width());
      end else if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
      no_idle = ($urandom_range(0, 4) == 0);
      send_random_line();
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    board.finish_check();

    $display("sent %0d code bytes over %0d lines, checked %0d decoded words",
             board.code_bytes, board.lines, board.words_checked);
    $display("%0d line width writes including 0 and 65535; clamped, cut and skipped runs mixed in",
             board.width_writes);
    if (board.mismatches == 0) $display("packbits_line_decoder_test OK");
    else $display("packbits_line_decoder_test NOT OK");
    $finish;
  end

endmodule

// File: packbits_line_decoder.f
hw/rtl/pbld_pkg.sv
hw/rtl/pbld_in_if.sv
hw/rtl/pbld_out_if.sv
hw/rtl/pbld_chunker.sv
hw/rtl/packbits_line_decoder.sv
verif/pbld_track_pkg.sv
verif/packbits_line_decoder_test.sv
